### sv/nmcs_pkg.sv
// ----------------------------------------------------------------------------
// nmcs_pkg: shared types and constants of the marker corner selector
// Item layouts for the candidate and result channels, register indexes and
// register reset values.
// ----------------------------------------------------------------------------
package nmcs_pkg;

  // Field widths fixed by the channel layout
  localparam int unsigned PIX_W  = 12;  // whole-pixel coordinates and frame size
  localparam int unsigned SIDE_W = 16;  // 12.4 fixed-point box sides and bounds
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  // Default width of a stored corner coordinate
  localparam int unsigned COORD_BITS_DEF = 12;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SQUARE_TOL   = 3'd4;

  // Register reset values
  localparam logic [PIX_W-1:0]  FRAME_WIDTH_RST  = 12'd1280;
  localparam logic [PIX_W-1:0]  FRAME_HEIGHT_RST = 12'd720;
  localparam logic [SIDE_W-1:0] SIDE_MIN_RST     = 16'd128;
  localparam logic [SIDE_W-1:0] SIDE_MAX_RST     = 16'd240;
  localparam logic [SIDE_W-1:0] SQUARE_TOL_RST   = 16'd32;

  // One candidate box
  typedef struct packed {
    logic [PIX_W-1:0]  center_x;
    logic [PIX_W-1:0]  center_y;
    logic [SIDE_W-1:0] box_width;
    logic [SIDE_W-1:0] box_height;
    logic              frame_start;
  } in_item_t;

  // One result: filter verdict and the four corners after the update
  typedef struct packed {
    logic             accepted;
    logic [PIX_W-1:0] top_left_x;
    logic [PIX_W-1:0] top_left_y;
    logic [PIX_W-1:0] bottom_left_x;
    logic [PIX_W-1:0] bottom_left_y;
    logic [PIX_W-1:0] top_right_x;
    logic [PIX_W-1:0] top_right_y;
    logic [PIX_W-1:0] bottom_right_x;
    logic [PIX_W-1:0] bottom_right_y;
  } out_item_t;

endpackage

### sv/nearest_marker_corner_selector_core.sv
// ----------------------------------------------------------------------------
// nearest_marker_corner_selector_core: marker corner selector
// Filters candidate boxes on size and squareness and keeps, for each of the
// four frame corners, the qualifying marker centre that lies nearest to it.
//
//   port group | dir | handshake          | carries
//   in_*       | in  | in_valid/in_stall  | one candidate box (in_item_t)
//   out_*      | out | out_valid/out_stall| verdict and four corners
//   cfg_*      | in  | cfg_we             | register index and data
//
// An item passes from acceptance into the input register, then through the
// filter, four parallel squared-distance compares and the corner update into
// the result register. One item is taken every cycle unless the result stalls;
// the rate is set by the single compare stage that updates the corner state.
// Reset (rst_n low, synchronous) clears the corners, the frame flag and both
// valid bits and loads the register defaults. A stalled result holds the
// input register, which then stalls the input channel; nothing is dropped.
// ----------------------------------------------------------------------------
module nearest_marker_corner_selector_core #(
  parameter int unsigned COORD_BITS = nmcs_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // candidate channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  nmcs_pkg::in_item_t                   in_data,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output nmcs_pkg::out_item_t                  out_data,
  // register writes
  input  logic                                 cfg_we,
  input  logic [nmcs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nmcs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import nmcs_pkg::*;

  // Width of coordinate differences: covers stored corners and frame size
  localparam int unsigned DW = (COORD_BITS > PIX_W) ? COORD_BITS : PIX_W;
  localparam int unsigned SQ_W = 2 * DW;
  localparam int unsigned DIST_W = SQ_W + 1;

  // Absolute difference of two coordinates
  function automatic logic [DW-1:0] abs_diff(input logic [DW-1:0] a,
                                             input logic [DW-1:0] b);
    logic [DW-1:0] r;
    r = (a > b) ? (a - b) : (b - a);
    return r;
  endfunction

  // Registers
  logic [PIX_W-1:0]      fw_r, fh_r;
  logic [SIDE_W-1:0]     smin_r, smax_r, tol_r;
  logic                  in_v_r, out_v_r;
  in_item_t              in_r;
  out_item_t             out_r;
  logic                  seen_r;
  logic [COORD_BITS-1:0] cx_r [4];
  logic [COORD_BITS-1:0] cy_r [4];

  // Next values
  logic                  in_v_nxt, out_v_nxt, seen_nxt;
  logic [COORD_BITS-1:0] cx_nxt [4];
  logic [COORD_BITS-1:0] cy_nxt [4];
  out_item_t             out_nxt;

  // Handshake and stage movement
  logic in_take, adv, res_free;

  assign res_free  = !out_v_r || !out_stall;
  assign adv       = in_v_r && res_free;
  assign in_stall  = in_v_r && !res_free;
  assign in_take   = in_valid && !in_stall;
  assign in_v_nxt  = in_take || (in_v_r && !adv);
  assign out_v_nxt = adv || (out_v_r && out_stall);

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Size and squareness filter
  logic [SIDE_W-1:0]     side_diff;
  logic                  ok;
  logic                  seen_eff;
  logic [COORD_BITS-1:0] cand_x, cand_y;

  assign side_diff = (in_r.box_width > in_r.box_height) ?
                     (in_r.box_width - in_r.box_height) :
                     (in_r.box_height - in_r.box_width);
  assign ok = (side_diff < tol_r) &&
              (in_r.box_height > smin_r) && (in_r.box_height < smax_r) &&
              (in_r.box_width > smin_r) && (in_r.box_width < smax_r);
  assign seen_eff = seen_r && !in_r.frame_start;
  assign cand_x   = COORD_BITS'(in_r.center_x);
  assign cand_y   = COORD_BITS'(in_r.center_y);
  assign seen_nxt = adv ? (seen_eff || ok) : seen_r;

  // Per-corner distance compare and update
  for (genvar k = 0; k < 4; k++) begin : g_corner
    logic [DW-1:0]     ref_x, ref_y;
    logic [DW-1:0]     dxn, dyn, dxc, dyc;
    logic [SQ_W-1:0]   sxn, syn, sxc, syc;
    logic [DIST_W-1:0] dist_new, dist_cur;
    logic              upd;

    // reference point: right-hand corners use the width, bottom ones the height
    assign ref_x = (k >= 2) ? DW'(fw_r) : '0;
    assign ref_y = ((k % 2) == 1) ? DW'(fh_r) : '0;

    assign dxn = abs_diff(ref_x, DW'(cand_x));
    assign dyn = abs_diff(ref_y, DW'(cand_y));
    assign dxc = abs_diff(ref_x, DW'(cx_r[k]));
    assign dyc = abs_diff(ref_y, DW'(cy_r[k]));

    assign sxn = dxn * dxn;
    assign syn = dyn * dyn;
    assign sxc = dxc * dxc;
    assign syc = dyc * dyc;

    assign dist_new = {1'b0, sxn} + {1'b0, syn};
    assign dist_cur = {1'b0, sxc} + {1'b0, syc};

    // first hit of a frame takes every corner; ties keep the old corner
    assign upd = adv && ok && (!seen_eff || (dist_new < dist_cur));

    assign cx_nxt[k] = upd ? cand_x : cx_r[k];
    assign cy_nxt[k] = upd ? cand_y : cy_r[k];
  end

  // Assemble the result from the updated corners
  always_comb begin
    out_nxt.accepted       = ok;
    out_nxt.top_left_x     = PIX_W'(cx_nxt[0]);
    out_nxt.top_left_y     = PIX_W'(cy_nxt[0]);
    out_nxt.bottom_left_x  = PIX_W'(cx_nxt[1]);
    out_nxt.bottom_left_y  = PIX_W'(cy_nxt[1]);
    out_nxt.top_right_x    = PIX_W'(cx_nxt[2]);
    out_nxt.top_right_y    = PIX_W'(cy_nxt[2]);
    out_nxt.bottom_right_x = PIX_W'(cx_nxt[3]);
    out_nxt.bottom_right_y = PIX_W'(cy_nxt[3]);
  end

  // Control state, registers and corners
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      seen_r  <= 1'b0;
      fw_r    <= FRAME_WIDTH_RST;
      fh_r    <= FRAME_HEIGHT_RST;
      smin_r  <= SIDE_MIN_RST;
      smax_r  <= SIDE_MAX_RST;
      tol_r   <= SQUARE_TOL_RST;
      for (int i = 0; i < 4; i++) begin
        cx_r[i] <= '0;
        cy_r[i] <= '0;
      end
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      seen_r  <= seen_nxt;
      for (int i = 0; i < 4; i++) begin
        cx_r[i] <= cx_nxt[i];
        cy_r[i] <= cy_nxt[i];
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  fw_r   <= cfg_wdata[PIX_W-1:0];
          REG_FRAME_HEIGHT: fh_r   <= cfg_wdata[PIX_W-1:0];
          REG_SIDE_MIN:     smin_r <= cfg_wdata[SIDE_W-1:0];
          REG_SIDE_MAX:     smax_r <= cfg_wdata[SIDE_W-1:0];
          REG_SQUARE_TOL:   tol_r  <= cfg_wdata[SIDE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload: load the input item on acceptance, the result on advance
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  // Checks
  logic corners_match;

  assign corners_match =
    (out_r.top_left_x     == PIX_W'(cx_r[0])) && (out_r.top_left_y     == PIX_W'(cy_r[0])) &&
    (out_r.bottom_left_x  == PIX_W'(cx_r[1])) && (out_r.bottom_left_y  == PIX_W'(cy_r[1])) &&
    (out_r.top_right_x    == PIX_W'(cx_r[2])) && (out_r.top_right_y    == PIX_W'(cy_r[2])) &&
    (out_r.bottom_right_x == PIX_W'(cx_r[3])) && (out_r.bottom_right_y == PIX_W'(cy_r[3]));

  // a waiting result always shows the live corner state
  a_result_tracks_corners: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> corners_match)
    else $error("result corners differ from corner state");

  // top-left and bottom-right corners move only when an item passes into the result register
  a_corners_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(cx_r[0]) && $stable(cy_r[0]) && $stable(cx_r[3]) &&
              $stable(cy_r[3])))
    else $error("corner changed without an advancing item");

  // a qualifying item marks the frame as seen
  a_seen_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && ok) |=> seen_r)
    else $error("frame flag not set after a qualifying item");

  // the input side stalls only behind a held item
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_v_r && out_v_r && out_stall))
    else $error("input stalled with free stages");

endmodule
